[rtl/vvt_pkg.sv]
// Shared constants, types and the quarter-wave sine table of the vertex view transform.
package vvt_pkg;

  // Quarter-wave sine table depth and derived widths.
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int SINE_PROD_W      = 14 + SINE_IDX_W;
  localparam int SINE_ENT_W       = 17;
  localparam int TRIG_W           = SINE_ENT_W + 1;

  // Fixed-point constants.
  localparam longint HALF_PI_Q30  = 64'sd1686629713;
  localparam int COORD_W          = 32;
  localparam int DIFF_W           = COORD_W + 1;
  localparam int ANGLE_W          = 16;
  localparam logic signed [36:0] CENTER_X = 37'sd26214400;  // 400.0 in Q16.16
  localparam logic signed [36:0] CENTER_Y = 37'sd19660800;  // 300.0 in Q16.16

  // Configuration port.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_CAM_X   = 3'd0,
    REG_CAM_Y   = 3'd1,
    REG_CAM_Z   = 3'd2,
    REG_YAW     = 3'd3,
    REG_PITCH   = 3'd4
  } reg_idx_t;

  // Register file contents as seen by the datapath.
  typedef struct packed {
    logic signed [COORD_W-1:0] cam_x;
    logic signed [COORD_W-1:0] cam_y;
    logic signed [COORD_W-1:0] cam_z;
    logic [ANGLE_W-1:0]        yaw_angle;
    logic [ANGLE_W-1:0]        pitch_angle;
  } cfg_regs_t;

  // Signed Q2.16 sine and cosine of both angles (18 bits, 16 fraction bits).
  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_yaw;
    logic signed [TRIG_W-1:0] cos_yaw;
    logic signed [TRIG_W-1:0] sin_pitch;
    logic signed [TRIG_W-1:0] cos_pitch;
  } trig_t;

  typedef logic [SINE_ENT_W-1:0] sine_tab_t [SINE_TABLE_DEPTH+1];

  // Builds the first quadrant of sine from a Taylor series up to the x^13 term.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    longint    x;
    longint    x2;
    longint    term;
    longint    sum;
    longint    val;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x    = (HALF_PI_Q30 * longint'(i)) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      sum  = x;
      term = ((x * x2) >> 30) / 6;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 42;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 110;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 156;
      sum  = sum + term;
      val  = (sum + 64'sd8192) >>> 14;
      if (val > 65536) begin
        val = 65536;
      end
      if (val < 0) begin
        val = 0;
      end
      tab[i] = val[SINE_ENT_W-1:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

[rtl/vvt_if.sv]
// Stream interfaces for vertices in and screen points out.
interface vvt_vertex_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic signed [31:0] vertex_z;

  modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
                  input ready);
  modport sink (input valid, input vertex_x, input vertex_y, input vertex_z,
                output ready);
endinterface

interface vvt_screen_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;

  modport source (output valid, output screen_x, output screen_y, input ready);
  modport sink (input valid, input screen_x, input screen_y, output ready);
endinterface

[rtl/vvt_cfg_regs.sv]
// APB-style register file holding the camera position and view angles.
module vvt_cfg_regs
  import vvt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_regs_t             cfg
);

  cfg_regs_t        cfg_r;
  cfg_regs_t        cfg_nxt;
  logic             wr_en;
  logic [2:0]       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg     = cfg_r;

  // Register write decode; addresses past the last register are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_CAM_X: begin
          cfg_nxt.cam_x = pwdata;
        end
        REG_CAM_Y: begin
          cfg_nxt.cam_y = pwdata;
        end
        REG_CAM_Z: begin
          cfg_nxt.cam_z = pwdata;
        end
        REG_YAW: begin
          cfg_nxt.yaw_angle = pwdata[ANGLE_W-1:0];
        end
        REG_PITCH: begin
          cfg_nxt.pitch_angle = pwdata[ANGLE_W-1:0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read-back mux.
  always_comb begin
    case (reg_idx)
      REG_CAM_X: prdata = cfg_r.cam_x;
      REG_CAM_Y: prdata = cfg_r.cam_y;
      REG_CAM_Z: prdata = cfg_r.cam_z;
      REG_YAW:   prdata = {{(CFG_DATA_W-ANGLE_W){1'b0}}, cfg_r.yaw_angle};
      REG_PITCH: prdata = {{(CFG_DATA_W-ANGLE_W){1'b0}}, cfg_r.pitch_angle};
      default:   prdata = '0;
    endcase
  end

endmodule

[rtl/vvt_trig.sv]
// Sine and cosine lookup for the yaw and pitch angles from the quarter-wave table.
module vvt_trig
  import vvt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_regs_t cfg,
  output trig_t     trig,
  output logic      trig_ok
);

  // Which of the four values a table read fills.
  typedef enum logic [1:0] {
    SEL_SIN_YAW   = 2'd0,
    SEL_COS_YAW   = 2'd1,
    SEL_SIN_PITCH = 2'd2,
    SEL_COS_PITCH = 2'd3
  } trig_sel_t;

  // Step count once all four reads have been issued.
  localparam logic [2:0] LOOKUP_DONE = 3'd4;

  // Table index for the position inside one quadrant.
  function automatic logic [SINE_IDX_W-1:0] quad_index(input logic [ANGLE_W-1:0] a);
    logic [SINE_PROD_W-1:0] prod;
    prod = SINE_PROD_W'(a[13:0]) * SINE_PROD_W'(SINE_TABLE_DEPTH);
    return prod[SINE_PROD_W-1:14];
  endfunction

  // Applies the quadrant sign to a table entry.
  function automatic logic signed [TRIG_W-1:0] signed_entry(
    input logic [SINE_ENT_W-1:0] ent,
    input logic                  neg
  );
    logic signed [TRIG_W-1:0] pos;
    pos = {1'b0, ent};
    return neg ? -pos : pos;
  endfunction

  trig_t                 trig_r;
  logic [ANGLE_W-1:0]    yaw_r;
  logic [ANGLE_W-1:0]    pitch_r;
  logic [2:0]            step_r;
  logic                  done_r;
  logic [SINE_ENT_W-1:0] rd_ent_r;
  logic                  rd_neg_r;
  trig_sel_t             rd_sel_r;
  logic                  rd_vld_r;
  logic                  angle_changed;
  logic [ANGLE_W-1:0]    ang;
  logic [1:0]            quad;
  logic [SINE_IDX_W-1:0] k;
  logic [SINE_IDX_W-1:0] rd_idx;
  logic                  rd_neg;

  assign angle_changed = (cfg.yaw_angle != yaw_r) || (cfg.pitch_angle != pitch_r);

  // Table address for the current step. Cosine is the sine one quadrant further
  // on, so it reads the mirrored entry in even quadrants and is negative in quadrants 1 and 2.
  always_comb begin
    ang    = step_r[1] ? pitch_r : yaw_r;
    quad   = ang[ANGLE_W-1:ANGLE_W-2];
    k      = quad_index(ang);
    rd_idx = (step_r[0] ^ quad[0]) ? SINE_IDX_W'(SINE_TABLE_DEPTH) - k : k;
    rd_neg = quad[1] ^ (step_r[0] & quad[0]);
  end

  // Lookup sequencer: after reset or an angle change, one table read per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_r    <= '0;
      pitch_r  <= '0;
      step_r   <= '0;
      done_r   <= 1'b0;
      rd_vld_r <= 1'b0;
    end else if (angle_changed) begin
      yaw_r    <= cfg.yaw_angle;
      pitch_r  <= cfg.pitch_angle;
      step_r   <= '0;
      done_r   <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= (step_r != LOOKUP_DONE);
      if (step_r != LOOKUP_DONE) begin
        step_r <= step_r + 3'd1;
      end
      if (rd_vld_r && rd_sel_r == SEL_COS_PITCH) begin
        done_r <= 1'b1;
      end
    end
  end

  // Registered table read.
  always_ff @(posedge clk) begin
    rd_ent_r <= SINE_TAB[rd_idx];
    rd_neg_r <= rd_neg;
    rd_sel_r <= trig_sel_t'(step_r[1:0]);
  end

  // Each read lands in its own signed value.
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      case (rd_sel_r)
        SEL_SIN_YAW:   trig_r.sin_yaw   <= signed_entry(rd_ent_r, rd_neg_r);
        SEL_COS_YAW:   trig_r.cos_yaw   <= signed_entry(rd_ent_r, rd_neg_r);
        SEL_SIN_PITCH: trig_r.sin_pitch <= signed_entry(rd_ent_r, rd_neg_r);
        SEL_COS_PITCH: trig_r.cos_pitch <= signed_entry(rd_ent_r, rd_neg_r);
        default: ;
      endcase
    end
  end

  assign trig    = trig_r;
  assign trig_ok = done_r && !angle_changed;

endmodule

[rtl/vvt_pipe.sv]
// Six-stage datapath: camera offset, yaw rotation, pitch rotation, centering, saturation.
module vvt_pipe
  import vvt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_regs_t cfg,
  input  trig_t     trig,
  input  logic      trig_ok,
  vvt_vertex_if.sink   in_vertex,
  vvt_screen_if.source out_screen
);

  localparam int NSTG = 6;

  // Saturates a centered coordinate to the signed 32-bit range.
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [36:0] val);
    logic signed [COORD_W-1:0] res;
    if ((&val[36:31]) || !(|val[36:31])) begin
      res = val[COORD_W-1:0];
    end else if (val[36]) begin
      res = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return res;
  endfunction

  logic [NSTG:1] v_r;
  logic [NSTG:1] en;

  // Stage 1: offsets from the camera.
  logic signed [DIFF_W-1:0] s1_rx_r, s1_ry_r, s1_rz_r;
  // Stage 2: yaw products.
  logic signed [50:0]       s2_rxcy_r, s2_rzsy_r, s2_rxsy_r, s2_rzcy_r;
  logic signed [DIFF_W-1:0] s2_ry_r;
  // Stage 3: rounded yaw rotation.
  logic signed [35:0]       s3_u_r, s3_w_r;
  logic signed [DIFF_W-1:0] s3_ry_r;
  // Stage 4: pitch products.
  logic signed [53:0]       s4_wsp_r;
  logic signed [50:0]       s4_rycp_r;
  logic signed [35:0]       s4_u_r;
  // Stage 5: rounded pitch rotation and finished x.
  logic signed [35:0]       s5_v_r;
  logic signed [COORD_W-1:0] s5_sx_r;
  // Stage 6: output register.
  logic signed [COORD_W-1:0] s6_sx_r, s6_sy_r;

  logic signed [51:0] u_sum, w_sum;
  logic signed [54:0] v_sum;

  // A stage loads when it is empty or its contents move on.
  always_comb begin
    en[NSTG] = !v_r[NSTG] || out_screen.ready;
    for (int i = NSTG - 1; i >= 1; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  // Input waits while the sine and cosine are being fetched.
  assign in_vertex.ready = rst_n && trig_ok && en[1];

  // Round half up on the 16 fraction bits of each product sum.
  always_comb begin
    u_sum = 52'(s2_rxcy_r) + 52'(s2_rzsy_r) + 52'sd32768;
    w_sum = 52'(s2_rzcy_r) - 52'(s2_rxsy_r) + 52'sd32768;
    v_sum = 55'(s4_rycp_r) - 55'(s4_wsp_r) + 55'sd32768;
  end

  // Valid bits follow the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_vertex.valid && in_vertex.ready;
      end
      for (int i = 2; i <= NSTG; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_rx_r <= {in_vertex.vertex_x[COORD_W-1], in_vertex.vertex_x}
               - {cfg.cam_x[COORD_W-1], cfg.cam_x};
      s1_ry_r <= {in_vertex.vertex_y[COORD_W-1], in_vertex.vertex_y}
               - {cfg.cam_y[COORD_W-1], cfg.cam_y};
      s1_rz_r <= {in_vertex.vertex_z[COORD_W-1], in_vertex.vertex_z}
               - {cfg.cam_z[COORD_W-1], cfg.cam_z};
    end
    if (en[2]) begin
      s2_rxcy_r <= s1_rx_r * trig.cos_yaw;
      s2_rzsy_r <= s1_rz_r * trig.sin_yaw;
      s2_rxsy_r <= s1_rx_r * trig.sin_yaw;
      s2_rzcy_r <= s1_rz_r * trig.cos_yaw;
      s2_ry_r   <= s1_ry_r;
    end
    if (en[3]) begin
      s3_u_r  <= u_sum[51:16];
      s3_w_r  <= w_sum[51:16];
      s3_ry_r <= s2_ry_r;
    end
    if (en[4]) begin
      s4_wsp_r  <= s3_w_r * trig.sin_pitch;
      s4_rycp_r <= s3_ry_r * trig.cos_pitch;
      s4_u_r    <= s3_u_r;
    end
    if (en[5]) begin
      s5_v_r  <= v_sum[51:16];
      s5_sx_r <= sat32(37'(s4_u_r) + CENTER_X);
    end
    if (en[6]) begin
      s6_sx_r <= s5_sx_r;
      s6_sy_r <= sat32(37'(s5_v_r) + CENTER_Y);
    end
  end

  assign out_screen.valid    = v_r[NSTG];
  assign out_screen.screen_x = s6_sx_r;
  assign out_screen.screen_y = s6_sy_r;

  // An accepted vertex always occupies the first stage next cycle.
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_vertex.valid && in_vertex.ready |=> v_r[1])
    else $error("accepted vertex did not enter the first stage");

  // A full pipeline with a stalled receiver must refuse input.
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r) && !out_screen.ready |-> !in_vertex.ready)
    else $error("input taken while the pipeline is full and stalled");

  // A bubble at the output is filled by the stage behind it.
  a_bubble_fills: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NSTG-1] && !v_r[NSTG] |=> v_r[NSTG])
    else $error("item did not advance into an empty output stage");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_screen.valid)
    else $error("result valid right after reset");

endmodule

[rtl/vertex_view_transform_unit.sv]
// Top level of the vertex view transform: register file, trig lookup and datapath.
//
// Usage:
//   Vertices arrive on in_vertex (signed Q16.16 x, y, z) and screen points leave
//   on out_screen (signed Q16.16 x, y, saturated), both valid/ready streams; a
//   transfer happens on a clock edge with valid and ready both high.
//   The camera position and the yaw and pitch angles sit in an APB register
//   file (cam_x 0x00, cam_y 0x04, cam_z 0x08, yaw 0x0C, pitch 0x10). Write
//   them while no vertex is in flight. After an angle changes, the four sine
//   and cosine values are read from the quarter-wave table one per cycle, and
//   in_vertex.ready stays low from the write until the last of them is stored.
//   A result appears on out_screen on reaching the last pipeline stage and can
//   transfer at the next edge. Throughput is one vertex per cycle unless a
//   lookup or an out_screen stall holds it, set by the six-stage pipeline with
//   one multiplier row per rotation. Reset (rst_n low, synchronous) clears the
//   registers to zero and empties the pipeline; in_vertex.ready stays low during
//   reset and after it, while the four sine and cosine values are read from the table.
//   When the receiver stalls, the results hold and the pipeline keeps taking
//   vertices until every stage is full, then in_vertex.ready drops.
module vertex_view_transform_unit
  import vvt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  vvt_vertex_if.sink            in_vertex,
  vvt_screen_if.source          out_screen,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_regs_t cfg;
  trig_t     trig;
  logic      trig_ok;

  // Configuration registers.
  vvt_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sine and cosine of the view angles.
  vvt_trig u_trig (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .trig    (trig),
    .trig_ok (trig_ok)
  );

  // Transform pipeline.
  vvt_pipe u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .trig       (trig),
    .trig_ok    (trig_ok),
    .in_vertex  (in_vertex),
    .out_screen (out_screen)
  );

endmodule
